// File: hdl/mbfr_pkg.sv
`default_nettype none

package mbfr_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 16;
  localparam int FB_W   = 6;
  localparam int LIDX_W = 10;
  localparam int SEEK_W = 15;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_SEEK  = 2'd2;
  localparam logic [OP_W-1:0] OP_RESET = 2'd3;

  localparam logic [FB_W-1:0] MAX_FIELD = 6'd32;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              ok;
    logic [POS_W-1:0]  pos;
  } mbfr_res_t;

endpackage

`default_nettype wire

// File: hdl/mbfr_if.sv
`default_nettype none

interface mbfr_in_if import mbfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [LIDX_W-1:0] load_index;
  logic [WORD_W-1:0] load_word;
  logic [FB_W-1:0]   field_bits;
  logic [SEEK_W-1:0] seek_position;

  modport source (output valid, opcode, load_index, load_word, field_bits, seek_position,
                  input ready);
  modport sink   (input valid, opcode, load_index, load_word, field_bits, seek_position,
                  output ready);
endinterface

interface mbfr_out_if import mbfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] field_value;
  logic              ok;
  logic [POS_W-1:0]  bit_position;

  modport source (output valid, field_value, ok, bit_position, input ready);
  modport sink   (input valid, field_value, ok, bit_position, output ready);
endinterface

interface mbfr_cfg_if import mbfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] bits_in_buffer;

  modport source (output valid, bits_in_buffer, input ready);
  modport sink   (input valid, bits_in_buffer, output ready);
endinterface

`default_nettype wire

// File: hdl/msb_first_bit_field_reader_top.sv
// Channel  Direction  Payload
// in_ch    sink       opcode, load_index, load_word, field_bits, seek_position
// out_ch   source     field_value, ok, bit_position
// cfg_ch   sink       bits_in_buffer
//
// Seek, position reset, zero-bit and failing reads go from accept straight to the emit state.
// A load and a successful read first reduce the word slot modulo
// WORD_DEPTH by a reciprocal multiply and a multiply-subtract, then the word store is
// written at one slot or read at two slots, with registered read data.
// Reset clears the position and the bit count; the word store is not cleared.
// A result that waits on out_ch does not block the next beat on in_ch.
`default_nettype none

module msb_first_bit_field_reader_top import mbfr_pkg::*; #(
  parameter int WORD_DEPTH = 1024
) (
  input  wire        clk,
  input  wire        rst_n,
  mbfr_in_if.sink    in_ch,
  mbfr_out_if.source out_ch,
  mbfr_cfg_if.sink   cfg_ch
);

  localparam int AW    = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
  localparam int N     = 12;
  localparam int SHIFT = N + $clog2(WORD_DEPTH);
  localparam longint MULT_L = ((64'd1 << SHIFT) + WORD_DEPTH - 1) / WORD_DEPTH;
  localparam logic [N:0] MULT = (N+1)'(MULT_L);
  localparam int PW    = 2*N + 1;
  localparam int QW    = N + 17;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_RED  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_EXT  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]        state_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  bib_r;
  logic              is_load_r;
  logic [FB_W-1:0]   fb_r;
  logic [WORD_W-1:0] ld_word_r;
  logic [N-1:0]      a_r;
  logic [PW-1:0]     prod_r;
  logic [N-1:0]      rem_r;
  logic [WORD_W-1:0] rd0_r;
  logic [WORD_W-1:0] rd1_r;
  mbfr_res_t         res_r;
  mbfr_res_t         out_r;
  logic              out_valid_r;

  logic [WORD_W-1:0] word_store [WORD_DEPTH];

  logic              in_fire;
  logic              out_free;
  logic [POS_W:0]    rd_end;
  logic              rd_fail;
  logic [N-1:0]      quot;
  logic [QW-1:0]     rem_w;
  logic [AW-1:0]     addr0;
  logic [AW:0]       addr1_w;
  logic [AW-1:0]     addr1;
  logic [2*WORD_W-1:0] joined;
  logic [WORD_W-1:0] head;
  logic [WORD_W-1:0] field;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.field_value  = out_r.value;
  assign out_ch.ok           = out_r.ok;
  assign out_ch.bit_position = out_r.pos;

  always_comb begin
    rd_end  = {1'b0, pos_r} + (POS_W+1)'(in_ch.field_bits);
    rd_fail = (in_ch.field_bits > MAX_FIELD) || (rd_end > {1'b0, bib_r});
    quot    = N'(prod_r >> SHIFT);
    rem_w   = QW'(a_r) - (QW'(quot) * QW'(WORD_DEPTH));
    addr0   = AW'(rem_r);
    addr1_w = (AW+1)'(addr0) + (AW+1)'(1);
    addr1   = (addr1_w == (AW+1)'(WORD_DEPTH)) ? '0 : addr1_w[AW-1:0];
    joined  = {rd0_r, rd1_r} << pos_r[4:0];
    head    = joined[2*WORD_W-1:WORD_W];
    field   = head >> (MAX_FIELD - fb_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ACC && is_load_r) begin
      word_store[addr0] <= ld_word_r;
    end
    rd0_r <= word_store[addr0];
    rd1_r <= word_store[addr1];
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(a_r) * PW'(MULT);
    rem_r  <= rem_w[N-1:0];
    if (in_fire) begin
      fb_r      <= in_ch.field_bits;
      ld_word_r <= in_ch.load_word;
      is_load_r <= (in_ch.opcode == OP_LOAD);
      if (in_ch.opcode == OP_LOAD) begin
        a_r <= N'(in_ch.load_index);
      end else begin
        a_r <= N'(pos_r[POS_W-1:5]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      bib_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        bib_r <= cfg_ch.bits_in_buffer;
        pos_r <= '0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            res_r.value <= '0;
            res_r.ok    <= 1'b1;
            res_r.pos   <= pos_r;
            state_r     <= ST_EMIT;
            case (in_ch.opcode)
              OP_LOAD: begin
                state_r <= ST_MUL;
              end
              OP_READ: begin
                if (in_ch.field_bits != '0) begin
                  if (rd_fail) begin
                    res_r.ok <= 1'b0;
                  end else begin
                    state_r <= ST_MUL;
                  end
                end
              end
              OP_SEEK: begin
                if ({1'b0, in_ch.seek_position} < bib_r) begin
                  pos_r     <= {1'b0, in_ch.seek_position};
                  res_r.pos <= {1'b0, in_ch.seek_position};
                end else begin
                  res_r.ok <= 1'b0;
                end
              end
              default: begin
                pos_r     <= '0;
                res_r.pos <= '0;
              end
            endcase
          end
        end
        ST_MUL: begin
          state_r <= ST_RED;
        end
        ST_RED: begin
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          state_r <= is_load_r ? ST_EMIT : ST_EXT;
        end
        ST_EXT: begin
          pos_r       <= pos_r + POS_W'(fb_r);
          res_r.pos   <= pos_r + POS_W'(fb_r);
          res_r.value <= field;
          state_r     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= bib_r)
    else $error("Bit position has passed the bit count.");

  a_slot_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> (QW'(rem_r) < QW'(WORD_DEPTH)))
    else $error("Word slot was not reduced below the store depth.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.ok) |-> (out_r.value == '0))
    else $error("A failed beat carries a non-zero field value.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("An accepted beat did not start work.");

endmodule

`default_nettype wire
